### sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge while out of reset
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/scqva_pkg.sv
// types, constants and codes of the sound command queue and voice allocator
`timescale 1ns / 1ps
package scqva_pkg;

  localparam int QUEUE_DEPTH  = 64;
  localparam int SAMPLE_COUNT = 128;
  localparam int VOICE_COUNT  = 23;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SAW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int VAW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  // input kinds
  localparam logic [2:0] KIND_PLAY   = 3'd0;
  localparam logic [2:0] KIND_PITCH  = 3'd1;
  localparam logic [2:0] KIND_VOLUME = 3'd2;
  localparam logic [2:0] KIND_STOP   = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;

  // result actions
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_QUEUED    = 4'd1;
  localparam logic [3:0] ACT_DROPPED   = 4'd2;
  localparam logic [3:0] ACT_START     = 4'd3;
  localparam logic [3:0] ACT_PITCH     = 4'd4;
  localparam logic [3:0] ACT_VOLUME    = 4'd5;
  localparam logic [3:0] ACT_KEY_OFF   = 4'd6;
  localparam logic [3:0] ACT_THROTTLED = 4'd7;
  localparam logic [3:0] ACT_NO_VOICE  = 4'd8;

  localparam logic [6:0]  PITCH_VOICE_MAX = 7'd23;
  localparam logic [6:0]  LEVEL_VOICE_MAX = 7'd99;
  localparam logic [31:0] THROTTLE_FRAMES = 32'd2;
  localparam logic [7:0]  THROTTLE_REPLY  = 8'd254;
  localparam logic [7:0]  GLOBAL_VOL_RST  = 8'd100;

  // floor(x / 100) = (x * PCT_RECIP) >> PCT_SHIFT, exact for x < 2^22
  localparam logic [22:0] PCT_RECIP = 23'd5368710;
  localparam int          PCT_SHIFT = 29;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  target;
    logic [13:0] volume;
    logic [13:0] pitch;
    logic        want_reply;
    logic [7:0]  reply_tag;
    logic [22:0] voice_busy;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [6:0]  voice;
    logic [6:0]  sample;
    logic [15:0] left_volume;
    logic [15:0] right_volume;
    logic [13:0] voice_pitch;
    logic        reply_valid;
    logic [7:0]  reply_id;
    logic [7:0]  reply_value;
  } res_t;

  // one queued command
  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  target;
    logic [13:0] volume;
    logic [13:0] pitch;
    logic        want_reply;
    logic [7:0]  tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SCALE,
    ST_EVAL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic load_imm;
    logic head_rd;
    logic lpf_rd;
    logic scale;
    logic eval;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic head_needed;
    logic out_free;
  } stat_t;

endpackage

### sv/scqva_if.sv
// valid/ready channels for commands, results and the volume register
`timescale 1ns / 1ps
interface scqva_cmd_if;
  import scqva_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scqva_res_if;
  import scqva_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scqva_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/scqva_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module scqva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### sv/scqva_ctrl.sv
// sequencing state machine for queue pushes and frame tick head handling
`timescale 1ns / 1ps
module scqva_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  scqva_pkg::stat_t stat_i,
  output scqva_pkg::ctrl_t ctrl_o
);
  import scqva_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && stat_i.out_free && stat_i.head_needed) begin
          state_d = ST_HEAD;
        end
      end
      ST_HEAD:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_EVAL;
      ST_EVAL: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = stat_i.out_free;
        ctrl_o.accept   = in_valid_i && stat_i.out_free;
        ctrl_o.head_rd  = ctrl_o.accept && stat_i.head_needed;
        ctrl_o.load_imm = ctrl_o.accept && !stat_i.head_needed;
      end
      ST_HEAD:  ctrl_o.lpf_rd = 1'b1;
      ST_SCALE: ctrl_o.scale = 1'b1;
      ST_EVAL:  ctrl_o.eval = stat_i.out_free;
      default:  ctrl_o = '0;
    endcase
  end
endmodule

### sv/scqva_dp.sv
// queue, throttle table, voice pick, volume scaling and result register
`timescale 1ns / 1ps
module scqva_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scqva_pkg::cmd_t  cmd_i,
  input  logic             cfg_valid_i,
  input  logic [7:0]       cfg_data_i,
  output logic             cfg_ready_o,
  input  logic             res_ready_i,
  output logic             res_valid_o,
  output scqva_pkg::res_t  res_o,
  input  scqva_pkg::ctrl_t ctrl_i,
  output scqva_pkg::stat_t stat_o
);
  import scqva_pkg::*;

  logic [QAW-1:0]          wp_q, rp_q, wp_next, rp_next;
  logic [31:0]             fc_q;
  logic [7:0]              gv_q;
  logic [22:0]             busy_q;
  logic [SAMPLE_COUNT-1:0] played_q;
  logic [21:0]             prod_q;
  logic [15:0]             scaled_q;
  logic [44:0]             recip_prod;
  res_t                    out_q;
  logic                    out_valid_q;

  logic                    is_push, is_tick, full, empty;
  entry_t                  head, new_entry;
  logic [31:0]             lpf_rdata;
  logic [SAW-1:0]          sidx;
  logic                    in_range, throttled, free_found;
  logic [VAW-1:0]          free_idx;
  logic                    lpf_we, played_set, rp_adv;
  res_t                    res_imm, res_eval;
  logic [ENTRY_W-1:0]      head_raw;

  assign is_push = (cmd_i.kind <= KIND_STOP);
  assign is_tick = (cmd_i.kind == KIND_TICK);
  assign wp_next = (wp_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_next = (rp_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign full    = (wp_next == rp_q);
  assign empty   = (wp_q == rp_q);

  assign stat_o.head_needed = is_tick && !empty;
  assign stat_o.out_free    = !out_valid_q || res_ready_i;
  assign cfg_ready_o        = 1'b1;

  assign new_entry.kind       = cmd_i.kind[1:0];
  assign new_entry.target     = cmd_i.target;
  assign new_entry.volume     = cmd_i.volume;
  assign new_entry.pitch      = cmd_i.pitch;
  assign new_entry.want_reply = (cmd_i.kind == KIND_PLAY) ? cmd_i.want_reply : 1'b0;
  assign new_entry.tag        = cmd_i.reply_tag;

  scqva_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_cmd_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.accept && is_push && !full),
    .waddr_i (wp_q),
    .wdata_i (new_entry),
    .re_i    (ctrl_i.head_rd),
    .raddr_i (rp_q),
    .rdata_o (head_raw)
  );
  assign head = entry_t'(head_raw);

  assign sidx     = head.target[SAW-1:0];
  assign in_range = (int'(head.target) < SAMPLE_COUNT);

  scqva_ram #(.WIDTH(32), .DEPTH(SAMPLE_COUNT)) u_lpf_ram (
    .clk_i   (clk_i),
    .we_i    (lpf_we),
    .waddr_i (sidx),
    .wdata_i (fc_q),
    .re_i    (ctrl_i.lpf_rd),
    .raddr_i (sidx),
    .rdata_o (lpf_rdata)
  );

  // distance taken modulo 2^32
  assign throttled = played_q[sidx] && ((fc_q - lpf_rdata) < THROTTLE_FRAMES);

  // lowest idle voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
      if (!busy_q[v]) begin
        free_found = 1'b1;
        free_idx   = VAW'(v);
      end
    end
  end

  assign recip_prod = prod_q * PCT_RECIP;

  always_comb begin
    res_imm = '0;
    if (is_push) begin
      res_imm.action = full ? ACT_DROPPED : ACT_QUEUED;
    end
  end

  always_comb begin
    res_eval   = '0;
    lpf_we     = 1'b0;
    played_set = 1'b0;
    rp_adv     = 1'b1;
    case (head.kind)
      KIND_PLAY[1:0]: begin
        if (in_range) begin
          res_eval.sample = head.target;
          if (throttled) begin
            res_eval.action = ACT_THROTTLED;
            if (head.want_reply) begin
              res_eval.reply_valid = 1'b1;
              res_eval.reply_id    = head.tag;
              res_eval.reply_value = THROTTLE_REPLY;
            end
          end else begin
            lpf_we     = ctrl_i.eval;
            played_set = ctrl_i.eval;
            if (free_found) begin
              res_eval.action       = ACT_START;
              res_eval.voice        = 7'(free_idx);
              res_eval.left_volume  = scaled_q;
              res_eval.right_volume = scaled_q;
              res_eval.voice_pitch  = head.pitch;
              if (head.want_reply) begin
                res_eval.reply_valid = 1'b1;
                res_eval.reply_id    = head.tag;
                res_eval.reply_value = 8'(free_idx);
              end
            end else begin
              // entry stays at the head for a later tick
              res_eval.action = ACT_NO_VOICE;
              rp_adv          = 1'b0;
            end
          end
        end
      end
      KIND_PITCH[1:0]: begin
        if (head.target <= PITCH_VOICE_MAX) begin
          res_eval.action      = ACT_PITCH;
          res_eval.voice       = head.target;
          res_eval.voice_pitch = head.pitch;
        end
      end
      KIND_VOLUME[1:0]: begin
        if (head.target <= LEVEL_VOICE_MAX) begin
          res_eval.action       = ACT_VOLUME;
          res_eval.voice        = head.target;
          res_eval.left_volume  = scaled_q;
          res_eval.right_volume = scaled_q;
        end
      end
      default: begin
        if (head.target <= LEVEL_VOICE_MAX) begin
          res_eval.action = ACT_KEY_OFF;
          res_eval.voice  = head.target;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      fc_q        <= '0;
      gv_q        <= GLOBAL_VOL_RST;
      played_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        gv_q <= cfg_data_i;
      end
      if (ctrl_i.accept && is_push && !full) begin
        wp_q <= wp_next;
      end
      if (ctrl_i.accept && is_tick) begin
        fc_q <= fc_q + 32'd1;
      end
      if (ctrl_i.eval && rp_adv) begin
        rp_q <= rp_next;
      end
      if (played_set) begin
        played_q[sidx] <= 1'b1;
      end
      if (ctrl_i.load_imm || ctrl_i.eval) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.head_rd) begin
      busy_q <= cmd_i.voice_busy;
    end
    if (ctrl_i.lpf_rd) begin
      prod_q <= head.volume * gv_q;
    end
    if (ctrl_i.scale) begin
      scaled_q <= recip_prod[PCT_SHIFT +: 16];
    end
    if (ctrl_i.load_imm) begin
      out_q <= res_imm;
    end else if (ctrl_i.eval) begin
      out_q <= res_eval;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
endmodule

### sv/sound_command_queue_voice_allocator.sv
// a push, a tick on an empty queue or an unknown kind gives its result in the next cycle
// a head tick passes the head, scale and eval states; eval waits for a free result register
// one push per cycle while the result register is free; a head tick runs the command ram
// read, the throttle ram read and the two multiply stages, and takes no input until done
// reset: queue pointers, frame count and played flags clear, global volume returns to 100
// the command and throttle rams are not cleared and need no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sound_command_queue_voice_allocator (
  input logic         clk_i,
  input logic         rst_ni,
  scqva_cmd_if.sink   cmd_i,
  scqva_res_if.source res_o,
  scqva_cfg_if.sink   cfg_i
);
  import scqva_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  cfg_ready;

  scqva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  scqva_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i.data),
    .cfg_valid_i (cfg_i.valid && cfg_ready),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .res_o       (res_o.data),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

  assign cmd_i.ready = ctrl.in_ready;
  assign cfg_i.ready = cfg_ready;

  // a new transaction is taken only when the result register can hold its result
  `ASSERT_CLKD(a_ready_out_free, cmd_i.ready |-> (!res_o.valid || res_o.ready), "input ready with result register blocked")
  // anything that does not touch the queue head answers in the next cycle
  `ASSERT_CLKD(a_imm_result, (cmd_i.valid && cmd_i.ready && !stat.head_needed) |=> res_o.valid, "immediate result missing")
  // replies only come with a started or throttled play
  `ASSERT_CLKD(a_reply_action, (res_o.valid && res_o.data.reply_valid) |-> (res_o.data.action == ACT_START || res_o.data.action == ACT_THROTTLED), "reply without play action")
  // head work never runs while input is offered as ready
  `ASSERT_ALWAYS(a_head_excl, (ctrl.lpf_rd || ctrl.scale || ctrl.eval) |-> !ctrl.in_ready, "input ready during head handling")
endmodule

### test/sound_command_queue_voice_allocator_tb.sv
// self-checking testbench for the sound command queue and voice allocator
`timescale 1ns / 1ps
module sound_command_queue_voice_allocator_tb;
  import scqva_pkg::*;

  localparam int          CLK_HALF      = 5;
  localparam int          RESET_CYCLES  = 10;
  localparam int          IDLE_LIMIT    = 2000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          ITEM_TARGET   = 950;
  localparam int          PHASE_COUNT   = 4;
  localparam int          PERCENT       = 100;
  localparam int          MAX_PRINTS    = 40;
  localparam logic [2:0]  KIND_SPARE_LO = 3'd5;
  localparam logic [2:0]  KIND_SPARE_HI = 3'd7;
  localparam logic [13:0] LEVEL_MAX     = 14'h3FFF;
  localparam logic [22:0] ALL_BUSY      = 23'h7FFFFF;

  typedef enum int {RX_OPEN, RX_COIN, RX_LONG_STALL} rx_mode_e;

  class voice_scoreboard;
    typedef struct packed {
      logic [2:0]  kind;
      logic [6:0]  target;
      logic [13:0] volume;
      logic [13:0] pitch;
      logic        want_reply;
      logic [7:0]  tag;
    } slot_t;

    slot_t          slots [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr;
    logic [QAW-1:0] rd_ptr;
    logic [31:0]    frame_no;
    logic [31:0]    last_start [SAMPLE_COUNT];
    bit             started [SAMPLE_COUNT];
    logic [7:0]     vol_pct;
    res_t           awaited [$];
    int             errors, results, starts, throttles, no_voice, drops;

    function new();
      wr_ptr   = '0;
      rd_ptr   = '0;
      frame_no = '0;
      vol_pct  = GLOBAL_VOL_RST;
      foreach (started[i]) started[i] = 1'b0;
    endfunction

    function logic [15:0] scaled(logic [13:0] level);
      logic [31:0] prod;
      prod = 32'(level) * 32'(vol_pct);
      return 16'(prod / PERCENT);
    endfunction

    // head entry handling on a tick; a play with no idle voice stays queued
    function res_t run_head(logic [22:0] busy);
      slot_t s;
      res_t  r;
      s = slots[rd_ptr];
      r = '0;
      if (s.kind == KIND_PLAY) begin
        if (int'(s.target) >= SAMPLE_COUNT) begin
          rd_ptr++;
          return r;
        end
        r.sample = s.target;
        if (started[s.target] && (frame_no - last_start[s.target]) < THROTTLE_FRAMES) begin
          r.action = ACT_THROTTLED;
          if (s.want_reply) begin
            r.reply_valid = 1'b1;
            r.reply_id    = s.tag;
            r.reply_value = THROTTLE_REPLY;
          end
          rd_ptr++;
          return r;
        end
        last_start[s.target] = frame_no;
        started[s.target]    = 1'b1;
        for (int v = 0; v < VOICE_COUNT; v++) begin
          if (!busy[v]) begin
            r.action       = ACT_START;
            r.voice        = 7'(v);
            r.left_volume  = scaled(s.volume);
            r.right_volume = scaled(s.volume);
            r.voice_pitch  = s.pitch;
            if (s.want_reply) begin
              r.reply_valid = 1'b1;
              r.reply_id    = s.tag;
              r.reply_value = 8'(v);
            end
            rd_ptr++;
            return r;
          end
        end
        r.action = ACT_NO_VOICE;
        return r;
      end
      case (s.kind)
        KIND_PITCH: begin
          if (s.target <= PITCH_VOICE_MAX) begin
            r.action      = ACT_PITCH;
            r.voice       = s.target;
            r.voice_pitch = s.pitch;
          end
        end
        KIND_VOLUME: begin
          if (s.target <= LEVEL_VOICE_MAX) begin
            r.action       = ACT_VOLUME;
            r.voice        = s.target;
            r.left_volume  = scaled(s.volume);
            r.right_volume = scaled(s.volume);
          end
        end
        default: begin
          if (s.target <= LEVEL_VOICE_MAX) begin
            r.action = ACT_KEY_OFF;
            r.voice  = s.target;
          end
        end
      endcase
      rd_ptr++;
      return r;
    endfunction

    function res_t predict(cmd_t c);
      res_t           r;
      logic [QAW-1:0] nxt;
      r = '0;
      if (c.kind <= KIND_STOP) begin
        nxt = wr_ptr + 1'b1;
        if (nxt == rd_ptr) begin
          r.action = ACT_DROPPED;
          return r;
        end
        slots[wr_ptr].kind       = c.kind;
        slots[wr_ptr].target     = c.target;
        slots[wr_ptr].volume     = c.volume;
        slots[wr_ptr].pitch      = c.pitch;
        slots[wr_ptr].want_reply = (c.kind == KIND_PLAY) ? c.want_reply : 1'b0;
        slots[wr_ptr].tag        = c.reply_tag;
        wr_ptr   = nxt;
        r.action = ACT_QUEUED;
      end else if (c.kind == KIND_TICK) begin
        frame_no++;
        if (wr_ptr != rd_ptr) r = run_head(c.voice_busy);
      end
      return r;
    endfunction

    function void note_cmd(cmd_t c);
      awaited.push_back(predict(c));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task compare_field(string field, logic [31:0] got_v, logic [31:0] want_v);
      if (got_v !== want_v)
        report($sformatf("result %0d: %s is %0d, expected %0d", results, field, got_v,
                         want_v));
    endtask

    task check_result(res_t got);
      res_t want;
      results++;
      if (awaited.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results));
        return;
      end
      want = awaited.pop_front();
      if (want.action == ACT_START) starts++;
      if (want.action == ACT_THROTTLED) throttles++;
      if (want.action == ACT_NO_VOICE) no_voice++;
      if (want.action == ACT_DROPPED) drops++;
      compare_field("action", 32'(got.action), 32'(want.action));
      compare_field("voice", 32'(got.voice), 32'(want.voice));
      compare_field("sample", 32'(got.sample), 32'(want.sample));
      compare_field("left_volume", 32'(got.left_volume), 32'(want.left_volume));
      compare_field("right_volume", 32'(got.right_volume), 32'(want.right_volume));
      compare_field("voice_pitch", 32'(got.voice_pitch), 32'(want.voice_pitch));
      compare_field("reply_valid", 32'(got.reply_valid), 32'(want.reply_valid));
      compare_field("reply_id", 32'(got.reply_id), 32'(want.reply_id));
      compare_field("reply_value", 32'(got.reply_value), 32'(want.reply_value));
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  scqva_cmd_if cmd_ch ();
  scqva_res_if res_ch ();
  scqva_cfg_if cfg_ch ();

  sound_command_queue_voice_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  voice_scoreboard sb;
  int       idle_cycles = 0;
  int       items_done  = 0;
  int       burst_left  = 0;
  rx_mode_e rx_mode     = RX_OPEN;
  int       rx_left     = 0;
  int       rx_stall    = 0;

  always #CLK_HALF clk_i = ~clk_i;

  // result side stalls on its own pattern, switching mode now and then
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(RX_OPEN, RX_LONG_STALL));
        rx_left = $urandom_range(50, 300);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN: res_ch.ready <= 1'b1;
        RX_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (rx_stall == 0) begin
            res_ch.ready <= 1'b1;
            rx_stall = $urandom_range(1, 30);
          end else begin
            res_ch.ready <= 1'b0;
            rx_stall--;
          end
        end
      endcase
    end
  end

  // results are checked before the command of the same edge is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
      if (cmd_ch.valid && cmd_ch.ready) sb.note_cmd(cmd_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) sb.vol_pct = cfg_ch.data;
      if ((res_ch.valid && res_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("no transaction for %0d cycles, giving up", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic cmd_t make_cmd(logic [2:0] kind, logic [6:0] target,
                                    logic [13:0] volume, logic [13:0] pitch, logic want,
                                    logic [7:0] tag, logic [22:0] busy);
    cmd_t c;
    c.kind       = kind;
    c.target     = target;
    c.volume     = volume;
    c.pitch      = pitch;
    c.want_reply = want;
    c.reply_tag  = tag;
    c.voice_busy = busy;
    return c;
  endfunction

  function automatic logic [2:0] push_kind();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return KIND_PLAY;
    if (roll < 7) return KIND_PITCH;
    if (roll < 9) return KIND_VOLUME;
    return KIND_STOP;
  endfunction

  function automatic cmd_t random_cmd(logic [2:0] kind);
    cmd_t c;
    c = make_cmd(kind, 7'($urandom), 14'($urandom), 14'($urandom), 1'($urandom),
                 8'($urandom), 23'($urandom));
    if ($urandom_range(0, 7) == 0) c.volume = $urandom_range(0, 1) ? LEVEL_MAX : 14'd0;
    if ($urandom_range(0, 7) == 0) c.pitch = $urandom_range(0, 1) ? LEVEL_MAX : 14'd0;
    // a small sample set makes replays close together, so throttling happens
    if ($urandom_range(0, 3) != 0) begin
      case (kind) inside
        KIND_PLAY:   c.target = 7'($urandom_range(0, 7));
        KIND_PITCH:  c.target = 7'($urandom_range(0, PITCH_VOICE_MAX));
        KIND_VOLUME,
        KIND_STOP:   c.target = 7'($urandom_range(0, LEVEL_VOICE_MAX));
        default:     ;
      endcase
    end
    case ($urandom_range(0, 5))
      0:       c.voice_busy = ALL_BUSY;
      1:       c.voice_busy = '0;
      2:       c.voice_busy = ALL_BUSY & ~(23'd1 << $urandom_range(0, VOICE_COUNT - 1));
      default: ;
    endcase
    return c;
  endfunction

  // sender works in bursts with gaps in between
  task automatic send_cmd(input cmd_t c);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    if (c.kind <= KIND_TICK) items_done++;
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_volume(input logic [7:0] pct);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= pct;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input int quota, input bit with_fill);
    int stop_at;
    int n;
    stop_at = items_done + quota;
    // overfill the queue so pushes get dropped, then drain it
    if (with_fill) begin
      for (int i = 0; i < QUEUE_DEPTH + 2; i++) send_cmd(random_cmd(push_kind()));
      for (int i = 0; i < QUEUE_DEPTH + 8; i++) send_cmd(random_cmd(KIND_TICK));
    end
    while (items_done < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(1, 6);
        repeat (n) send_cmd(random_cmd(push_kind()));
        repeat ($urandom_range(1, n + 2)) send_cmd(random_cmd(KIND_TICK));
      end else begin
        repeat ($urandom_range(1, 4))
          send_cmd(random_cmd(3'($urandom_range(KIND_PLAY, KIND_SPARE_HI))));
      end
    end
    settle();
  endtask

  initial begin
    logic [7:0] plan [PHASE_COUNT];
    sb = new();
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on an empty queue and the spare kinds, all fields at their extremes
    send_cmd(make_cmd(KIND_TICK, 7'd0, 14'd0, 14'd0, 1'b0, 8'd0, 23'd0));
    send_cmd(make_cmd(KIND_SPARE_LO, 7'h7F, LEVEL_MAX, LEVEL_MAX, 1'b1, 8'hFF, ALL_BUSY));
    send_cmd(make_cmd(KIND_SPARE_HI, 7'd0, 14'd0, 14'd0, 1'b0, 8'd0, 23'd0));
    // first play starts voice 0, a replay one frame later is throttled
    send_cmd(make_cmd(KIND_PLAY, 7'd0, LEVEL_MAX, LEVEL_MAX, 1'b1, 8'hFF, 23'd0));
    send_cmd(make_cmd(KIND_TICK, 7'd0, 14'd0, 14'd0, 1'b0, 8'd0, 23'd0));
    send_cmd(make_cmd(KIND_PLAY, 7'd0, 14'd77, 14'd99, 1'b1, 8'd0, 23'd0));
    send_cmd(make_cmd(KIND_TICK, 7'h7F, LEVEL_MAX, LEVEL_MAX, 1'b1, 8'hFF, 23'd0));
    // all voices busy keeps the play queued, the retry then gets throttled
    send_cmd(make_cmd(KIND_PLAY, 7'h7F, 14'd0, 14'd0, 1'b1, 8'hA5, 23'd0));
    send_cmd(make_cmd(KIND_TICK, 7'd0, 14'd0, 14'd0, 1'b0, 8'd0, ALL_BUSY));
    send_cmd(make_cmd(KIND_TICK, 7'd0, 14'd0, 14'd0, 1'b0, 8'd0, ALL_BUSY));
    // only the top voice idle
    send_cmd(make_cmd(KIND_PLAY, 7'd5, 14'd1234, 14'd4321, 1'b0, 8'h5A, 23'd0));
    send_cmd(make_cmd(KIND_TICK, 7'd0, 14'd0, 14'd0, 1'b0, 8'd0,
                      ALL_BUSY & ~(23'd1 << (VOICE_COUNT - 1))));
    // voice range limits of pitch, volume and key off
    send_cmd(make_cmd(KIND_PITCH, PITCH_VOICE_MAX, 14'd0, LEVEL_MAX, 1'b1, 8'd1, 23'd0));
    send_cmd(make_cmd(KIND_PITCH, PITCH_VOICE_MAX + 7'd1, 14'd0, 14'd5, 1'b0, 8'd2, 23'd0));
    send_cmd(make_cmd(KIND_VOLUME, LEVEL_VOICE_MAX, LEVEL_MAX, 14'd0, 1'b0, 8'd3, 23'd0));
    send_cmd(make_cmd(KIND_VOLUME, 7'h7F, 14'd500, 14'd0, 1'b1, 8'd4, 23'd0));
    send_cmd(make_cmd(KIND_STOP, 7'd0, 14'd0, 14'd0, 1'b0, 8'd5, 23'd0));
    send_cmd(make_cmd(KIND_STOP, LEVEL_VOICE_MAX + 7'd1, 14'd0, 14'd0, 1'b0, 8'd6, 23'd0));
    repeat (6) send_cmd(random_cmd(KIND_TICK));
    settle();

    plan[0] = 8'd0;
    plan[1] = 8'd255;
    plan[2] = 8'($urandom_range(1, 254));
    plan[3] = GLOBAL_VOL_RST;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_volume(plan[p]);
      run_phase((ITEM_TARGET - items_done) / (PHASE_COUNT - p), (p % 2) == 0);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited.size()));

    $display("summary: %0d commands, %0d results checked, global volume 100, 0, 255, %0d, 100",
             items_done, sb.results, plan[2]);
    $display("summary: %0d starts, %0d throttled, %0d no free voice, %0d dropped, %0d errors",
             sb.starts, sb.throttles, sb.no_voice, sb.drops, sb.errors);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
